// ===== rtl/gps_pkg.sv =====
// Shared types and constants for the polar Gaussian sampler pipeline.
// Used by the top level and the step modules under rtl; depends on nothing else.
package gps_pkg;

    localparam int LogSteps  = 58;
    localparam int DivSteps  = 64;
    localparam int SqrtSteps = 32;

    // 2*ln(2) in Q1.63, rounded.
    localparam logic [63:0] TWO_LN2_Q63 = 64'hB17217F7D1CF79AC;

    typedef struct packed {
        logic        su;
        logic        sv;
        logic [61:0] cu2;
        logic [61:0] cv2;
        logic [61:0] s;
    } pair_t;

    typedef struct packed {
        pair_t       pair;
        logic [5:0]  e;
    } log_side_t;

    typedef struct packed {
        logic        su;
        logic        sv;
        logic [61:0] s;
    } div_side_t;

    typedef struct packed {
        logic [61:0] rem;
        logic [63:0] lq;
    } div_lane_t;

    typedef struct packed {
        logic su;
        logic sv;
    } sq_side_t;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] r;
    } sq_lane_t;

endpackage

// ===== rtl/gaussian_polar_sampler_top.sv =====
// Top level of the polar Gaussian sampler: front end, logarithm, scaling,
// division and square-root pipelines, and the output word buffer.
// Depends on gps_pkg, gps_mul64, gps_log_step, gps_div_step, gps_sqrt_step.
//
// Usage: the input channel (in_valid/in_ready, u_word, v_word) takes one pair
// of uniform words per cycle while in_ready is high. A pair inside the unit
// circle (and not at its center) yields two output words on out_valid/out_ready:
// u*f first with last_of_pair low, then v*f with last_of_pair high. A rejected
// pair yields nothing. Outputs are Q4.27 two's complement.
// The second word of a pair follows the first in the next cycle if the receiver
// takes the first. The pipeline moves one stage per cycle while it is not frozen;
// the single output port hands out a kept pair's two words one after the other,
// so kept pairs limit the sustained rate, and rejected pairs are taken at one
// pair per cycle.
// A reset clears every stage valid bit and the output buffer; no words are in
// flight afterwards. When the receiver stalls, the buffer holds its pair and
// the whole pipeline freezes as soon as a finished pair is waiting behind it,
// which also drops in_ready.
module gaussian_polar_sampler_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        u_word,
    input  logic [31:0]        v_word,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] normal_value,
    output logic               last_of_pair
);
    import gps_pkg::*;

    logic en;

    // Front end.
    logic        a_vld_reg;
    logic        a_su_reg;
    logic        a_sv_reg;
    logic [31:0] a_au_reg;
    logic [31:0] a_av_reg;
    logic        b_vld_reg;
    logic        b_su_reg;
    logic        b_sv_reg;
    logic [63:0] b_cu2_reg;
    logic [63:0] b_cv2_reg;
    logic        c_vld_reg;
    pair_t       c_pair_reg;
    logic        d_vld_reg;
    pair_t       d_pair_reg;
    logic [5:0]  d_e_reg;
    logic        e_vld_reg;
    log_side_t   e_side_reg;
    logic [63:0] e_m_reg;

    logic [31:0] au_next;
    logic [31:0] av_next;
    logic [63:0] s_sum;
    logic        keep;
    pair_t       c_pair_next;
    logic [5:0]  e_next;
    logic [63:0] m_next;

    // Logarithm chain.
    logic        lv    [LogSteps+1];
    logic [63:0] lm    [LogSteps+1];
    logic [57:0] lf    [LogSteps+1];
    log_side_t   lside [LogSteps+1];

    // -2 ln s and scaling.
    logic         t_vld_reg;
    pair_t        t_pair_reg;
    logic [63:0]  t_t_reg;
    logic [63:0]  t_next;
    logic         k1_vld_reg;
    pair_t        k1_pair_reg;
    logic         k2_vld_reg;
    pair_t        k2_pair_reg;
    logic [127:0] k_prod;
    logic [62:0]  g;
    logic         l1_vld_reg;
    div_side_t    l1_side_reg;
    logic         l2_vld_reg;
    div_side_t    l2_side_reg;
    logic [127:0] wu_prod;
    logic [127:0] wv_prod;

    // Division chain.
    logic      dv    [DivSteps+1];
    div_side_t dside [DivSteps+1];
    div_lane_t du    [DivSteps+1];
    div_lane_t dvl   [DivSteps+1];

    // Square-root chain.
    logic     qv    [SqrtSteps+1];
    sq_side_t qside [SqrtSteps+1];
    sq_lane_t qu    [SqrtSteps+1];
    sq_lane_t qvl   [SqrtSteps+1];

    // Final rounding and output buffer.
    logic        f_vld_reg;
    logic [31:0] f_u_reg;
    logic [31:0] f_v_reg;
    logic        t_full_reg;
    logic        t_phase_reg;
    logic [31:0] t_u_reg;
    logic [31:0] t_v_reg;
    logic        release_pair;
    logic        tail_free;
    logic        load;

    function automatic logic [31:0] to_q27(input logic neg, input logic [31:0] root);
        logic [32:0] inc;
        logic [31:0] mag;
        logic [31:0] res;
        begin
            inc = {1'b0, root} + 33'd1;
            mag = inc[32:1];
            if (neg)
            begin
                if (mag > 32'h8000_0000)
                    mag = 32'h8000_0000;
                res = 32'd0 - mag;
            end
            else
            begin
                if (mag > 32'h7FFF_FFFF)
                    mag = 32'h7FFF_FFFF;
                res = mag;
            end
            return res;
        end
    endfunction

    // Pipeline advance: everything moves unless a finished pair has nowhere to go.
    assign release_pair = t_full_reg & out_ready & t_phase_reg;
    assign tail_free    = ~t_full_reg | release_pair;
    assign en           = ~f_vld_reg | tail_free;
    assign load         = f_vld_reg & tail_free;
    assign in_ready     = en;

    always_comb
    begin
        // A word below the midpoint maps to a negative component.
        au_next = u_word[31] ? {1'b0, u_word[30:0]} : (32'h8000_0000 - u_word);
        av_next = v_word[31] ? {1'b0, v_word[30:0]} : (32'h8000_0000 - v_word);

        s_sum = b_cu2_reg + b_cv2_reg;
        keep  = (s_sum != 64'd0) && (s_sum[63:62] == 2'b00);
        c_pair_next.su  = b_su_reg;
        c_pair_next.sv  = b_sv_reg;
        c_pair_next.cu2 = b_cu2_reg[61:0];
        c_pair_next.cv2 = b_cv2_reg[61:0];
        c_pair_next.s   = s_sum[61:0];

        e_next = 6'd0;
        for (int i = 0; i < 62; i++)
        begin
            if (c_pair_reg.s[i])
                e_next = 6'(i);
        end

        m_next = {2'b00, d_pair_reg.s} << (6'd63 - d_e_reg);

        t_next = {(6'd62 - lside[LogSteps].e), 58'b0} - {6'b0, lf[LogSteps]};
    end

    assign g = k_prod[127:65];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            c_vld_reg  <= 1'b0;
            d_vld_reg  <= 1'b0;
            e_vld_reg  <= 1'b0;
            t_vld_reg  <= 1'b0;
            k1_vld_reg <= 1'b0;
            k2_vld_reg <= 1'b0;
            l1_vld_reg <= 1'b0;
            l2_vld_reg <= 1'b0;
            f_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg  <= in_valid;
            b_vld_reg  <= a_vld_reg;
            c_vld_reg  <= b_vld_reg & keep;
            d_vld_reg  <= c_vld_reg;
            e_vld_reg  <= d_vld_reg;
            t_vld_reg  <= lv[LogSteps];
            k1_vld_reg <= t_vld_reg;
            k2_vld_reg <= k1_vld_reg;
            l1_vld_reg <= k2_vld_reg;
            l2_vld_reg <= l1_vld_reg;
            f_vld_reg  <= qv[SqrtSteps];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_su_reg    <= ~u_word[31];
            a_sv_reg    <= ~v_word[31];
            a_au_reg    <= au_next;
            a_av_reg    <= av_next;
            b_su_reg    <= a_su_reg;
            b_sv_reg    <= a_sv_reg;
            b_cu2_reg   <= a_au_reg * a_au_reg;
            b_cv2_reg   <= a_av_reg * a_av_reg;
            c_pair_reg  <= c_pair_next;
            d_pair_reg  <= c_pair_reg;
            d_e_reg     <= e_next;
            e_side_reg.pair <= d_pair_reg;
            e_side_reg.e    <= d_e_reg;
            e_m_reg     <= m_next;
            t_pair_reg  <= lside[LogSteps].pair;
            t_t_reg     <= t_next;
            k1_pair_reg <= t_pair_reg;
            k2_pair_reg <= k1_pair_reg;
            l1_side_reg.su <= k2_pair_reg.su;
            l1_side_reg.sv <= k2_pair_reg.sv;
            l1_side_reg.s  <= k2_pair_reg.s;
            l2_side_reg <= l1_side_reg;
            f_u_reg     <= to_q27(qside[SqrtSteps].su, qu[SqrtSteps].r[31:0]);
            f_v_reg     <= to_q27(qside[SqrtSteps].sv, qvl[SqrtSteps].r[31:0]);
        end
    end

    // Logarithm: one result bit per squaring step.
    assign lv[0]    = e_vld_reg;
    assign lm[0]    = e_m_reg;
    assign lf[0]    = 58'd0;
    assign lside[0] = e_side_reg;

    for (genvar gi = 0; gi < LogSteps; gi++)
    begin : g_log
        gps_log_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (lv[gi]),
            .in_m     (lm[gi]),
            .in_f     (lf[gi]),
            .in_side  (lside[gi]),
            .out_vld  (lv[gi+1]),
            .out_m    (lm[gi+1]),
            .out_f    (lf[gi+1]),
            .out_side (lside[gi+1])
        );
    end

    gps_mul64 u_mul_k (
        .clk  (clk),
        .en   (en),
        .a    (TWO_LN2_Q63),
        .b    (t_t_reg),
        .prod (k_prod)
    );

    gps_mul64 u_mul_u (
        .clk  (clk),
        .en   (en),
        .a    ({2'b00, k2_pair_reg.cu2}),
        .b    ({1'b0, g}),
        .prod (wu_prod)
    );

    gps_mul64 u_mul_v (
        .clk  (clk),
        .en   (en),
        .a    ({2'b00, k2_pair_reg.cv2}),
        .b    ({1'b0, g}),
        .prod (wv_prod)
    );

    // The quotient fits in 64 bits, so the high half is already the first remainder.
    assign dv[0]        = l2_vld_reg;
    assign dside[0]     = l2_side_reg;
    assign du[0].rem    = wu_prod[125:64];
    assign du[0].lq     = wu_prod[63:0];
    assign dvl[0].rem   = wv_prod[125:64];
    assign dvl[0].lq    = wv_prod[63:0];

    for (genvar gd = 0; gd < DivSteps; gd++)
    begin : g_div
        gps_div_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (dv[gd]),
            .in_side  (dside[gd]),
            .in_u     (du[gd]),
            .in_v     (dvl[gd]),
            .out_vld  (dv[gd+1]),
            .out_side (dside[gd+1]),
            .out_u    (du[gd+1]),
            .out_v    (dvl[gd+1])
        );
    end

    assign qv[0]       = dv[DivSteps];
    assign qside[0].su = dside[DivSteps].su;
    assign qside[0].sv = dside[DivSteps].sv;
    assign qu[0].x     = du[DivSteps].lq;
    assign qu[0].r     = 64'd0;
    assign qvl[0].x    = dvl[DivSteps].lq;
    assign qvl[0].r    = 64'd0;

    for (genvar gs = 0; gs < SqrtSteps; gs++)
    begin : g_sqrt
        gps_sqrt_step #(
            .BIT_POS (2 * (SqrtSteps - 1 - gs))
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (qv[gs]),
            .in_side  (qside[gs]),
            .in_u     (qu[gs]),
            .in_v     (qvl[gs]),
            .out_vld  (qv[gs+1]),
            .out_side (qside[gs+1]),
            .out_u    (qu[gs+1]),
            .out_v    (qvl[gs+1])
        );
    end

    // Output buffer: holds one pair and hands out its two words in order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_full_reg  <= 1'b0;
            t_phase_reg <= 1'b0;
        end
        else if (load)
        begin
            t_full_reg  <= 1'b1;
            t_phase_reg <= 1'b0;
        end
        else if (release_pair)
        begin
            t_full_reg  <= 1'b0;
            t_phase_reg <= 1'b0;
        end
        else if (t_full_reg && out_ready)
        begin
            t_phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            t_u_reg <= f_u_reg;
            t_v_reg <= f_v_reg;
        end
    end

    assign out_valid    = t_full_reg;
    assign normal_value = t_phase_reg ? t_v_reg : t_u_reg;
    assign last_of_pair = t_phase_reg;

endmodule

// ===== rtl/gps_mul64.sv =====
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
// Datapath only; depends on nothing else.
module gps_mul64 (
    input  logic         clk,
    input  logic         en,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] prod
);

    logic [63:0]  p00_reg;
    logic [63:0]  p01_reg;
    logic [63:0]  p10_reg;
    logic [63:0]  p11_reg;
    logic [127:0] prod_reg;
    logic [127:0] prod_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg  <= a[31:0]  * b[31:0];
            p01_reg  <= a[31:0]  * b[63:32];
            p10_reg  <= a[63:32] * b[31:0];
            p11_reg  <= a[63:32] * b[63:32];
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        prod_next = {p11_reg, p00_reg}
                  + {32'b0, p01_reg, 32'b0}
                  + {32'b0, p10_reg, 32'b0};
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/gps_log_step.sv =====
// One bit of the base-2 logarithm: square the Q1.63 mantissa and renormalize.
// Two register stages; depends on gps_pkg.
module gps_log_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [63:0]       in_m,
    input  logic [57:0]       in_f,
    input  gps_pkg::log_side_t in_side,
    output logic              out_vld,
    output logic [63:0]       out_m,
    output logic [57:0]       out_f,
    output gps_pkg::log_side_t out_side
);
    import gps_pkg::*;

    logic        v1_reg;
    logic [63:0] p00_reg;
    logic [63:0] p10_reg;
    logic [63:0] p11_reg;
    logic [57:0] f1_reg;
    log_side_t   side1_reg;

    logic        v2_reg;
    logic [63:0] m2_reg;
    logic [57:0] f2_reg;
    log_side_t   side2_reg;

    logic [127:0] sq;
    logic [63:0]  m_next;
    logic [57:0]  f_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg   <= in_m[31:0]  * in_m[31:0];
            p10_reg   <= in_m[63:32] * in_m[31:0];
            p11_reg   <= in_m[63:32] * in_m[63:32];
            f1_reg    <= in_f;
            side1_reg <= in_side;
            m2_reg    <= m_next;
            f2_reg    <= f_next;
            side2_reg <= side1_reg;
        end
    end

    // The cross term appears twice, hence the extra shift by one.
    always_comb
    begin
        sq     = {p11_reg, p00_reg} + {31'b0, p10_reg, 33'b0};
        m_next = sq[127] ? sq[127:64] : sq[126:63];
        f_next = {f1_reg[56:0], sq[127]};
    end

    assign out_vld  = v2_reg;
    assign out_m    = m2_reg;
    assign out_f    = f2_reg;
    assign out_side = side2_reg;

endmodule

// ===== rtl/gps_div_step.sv =====
// One restoring-division step for both lanes against the shared divisor s.
// One register stage; depends on gps_pkg.
module gps_div_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  gps_pkg::div_side_t in_side,
    input  gps_pkg::div_lane_t in_u,
    input  gps_pkg::div_lane_t in_v,
    output logic               out_vld,
    output gps_pkg::div_side_t out_side,
    output gps_pkg::div_lane_t out_u,
    output gps_pkg::div_lane_t out_v
);
    import gps_pkg::*;

    logic      vld_reg;
    div_side_t side_reg;
    div_lane_t u_reg;
    div_lane_t v_reg;
    div_lane_t u_next;
    div_lane_t v_next;

    function automatic div_lane_t step(input div_lane_t cur, input logic [61:0] d);
        logic [62:0] r2;
        logic [62:0] diff;
        logic        ge;
        div_lane_t   res;
        begin
            r2   = {cur.rem, cur.lq[63]};
            diff = r2 - {1'b0, d};
            ge   = (r2 >= {1'b0, d});
            res.rem = ge ? diff[61:0] : r2[61:0];
            res.lq  = {cur.lq[62:0], ge};
            return res;
        end
    endfunction

    always_comb
    begin
        u_next = step(in_u, in_side.s);
        v_next = step(in_v, in_side.s);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= in_side;
            u_reg    <= u_next;
            v_reg    <= v_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_side = side_reg;
    assign out_u    = u_reg;
    assign out_v    = v_reg;

endmodule

// ===== rtl/gps_sqrt_step.sv =====
// One digit of the integer square root for both lanes.
// One register stage; depends on gps_pkg.
module gps_sqrt_step #(
    parameter int BIT_POS = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  gps_pkg::sq_side_t in_side,
    input  gps_pkg::sq_lane_t in_u,
    input  gps_pkg::sq_lane_t in_v,
    output logic              out_vld,
    output gps_pkg::sq_side_t out_side,
    output gps_pkg::sq_lane_t out_u,
    output gps_pkg::sq_lane_t out_v
);
    import gps_pkg::*;

    localparam logic [63:0] BitVal = 64'd1 << BIT_POS;

    logic     vld_reg;
    sq_side_t side_reg;
    sq_lane_t u_reg;
    sq_lane_t v_reg;
    sq_lane_t u_next;
    sq_lane_t v_next;

    function automatic sq_lane_t step(input sq_lane_t cur);
        logic [64:0] trial;
        logic        ge;
        sq_lane_t    res;
        begin
            trial = {1'b0, cur.r} + {1'b0, BitVal};
            ge    = ({1'b0, cur.x} >= trial);
            res.x = ge ? (cur.x - trial[63:0]) : cur.x;
            res.r = ge ? ((cur.r >> 1) + BitVal) : (cur.r >> 1);
            return res;
        end
    endfunction

    always_comb
    begin
        u_next = step(in_u);
        v_next = step(in_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= in_side;
            u_reg    <= u_next;
            v_reg    <= v_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_side = side_reg;
    assign out_u    = u_reg;
    assign out_v    = v_reg;

endmodule

// ===== rtl/gps_checker.sv =====
// Port-level checks for the polar Gaussian sampler, bound to its top level.
// Depends only on the ports of gaussian_polar_sampler_top.
module gps_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] normal_value,
    input logic        last_of_pair
);

    // A stalled output word holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(normal_value)
                                    && $stable(last_of_pair))
        else $error("stalled output word changed");

    // The first word of a pair is always followed by its second word.
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_pair |=> out_valid && last_of_pair)
        else $error("first word of a pair not followed by the second");

    // A new run of output words starts with the first word of a pair.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !last_of_pair)
        else $error("output started on the second word of a pair");

    // The input side only waits when a word is waiting at the output.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no output word pending");

    // Samples stay well inside the Q4.27 range.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(normal_value) < 32'sd1300000000)
                   && ($signed(normal_value) > -32'sd1300000000))
        else $error("sample magnitude out of range");

endmodule

bind gaussian_polar_sampler_top gps_port_checker u_gps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .normal_value (normal_value),
    .last_of_pair (last_of_pair)
);

// ===== bench/gps_checker.sv =====
// Checker for the polar Gaussian sampler: watches both channels, predicts
// each pair's normal words and compares them in order. Does not depend on gps_pkg.
module gps_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [31:0]        u_word,
    input  logic [31:0]        v_word,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] normal_value,
    input  logic               last_of_pair,
    output int                 errors,
    output int                 pending
);

    localparam logic [63:0] TWO_LN2 = 64'hB17217F7D1CF79AC;
    localparam int          LOG_BITS = 58;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
    } normal_word_t;

    normal_word_t normal_q[$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Scales one component by sqrt(-2 ln s / s), rounds to Q4.27 and saturates.
    function automatic logic [31:0] scale_component(input logic signed [63:0] c,
                                                    input logic [63:0] g,
                                                    input logic [63:0] s);
        logic [63:0]  mag;
        logic [127:0] w;
        logic [63:0]  r;
        mag = (c < 0) ? 64'(-c) : 64'(c);
        w = (128'(mag * mag) * 128'(g)) / 128'(s);
        r = (int_sqrt(w[63:0]) + 64'd1) >> 1;
        if (c < 0)
        begin
            if (r > 64'h8000_0000)
                r = 64'h8000_0000;
            return 32'(64'd0 - r);
        end
        if (r > 64'h7FFF_FFFF)
            r = 64'h7FFF_FFFF;
        return r[31:0];
    endfunction

    // Returns 1 when the pair lies inside the unit circle and not at its center.
    function automatic logic predict_normals(input logic [31:0] uw, input logic [31:0] vw,
                                             output logic [31:0] nu, output logic [31:0] nv);
        logic signed [63:0] ui;
        logic signed [63:0] vi;
        logic [63:0]        au;
        logic [63:0]        av;
        logic [63:0]        s;
        logic [63:0]        m;
        logic [63:0]        f;
        logic [63:0]        t;
        logic [127:0]       prod;
        int                 e;
        ui = $signed({32'd0, uw}) - 64'sh8000_0000;
        vi = $signed({32'd0, vw}) - 64'sh8000_0000;
        au = (ui < 0) ? 64'(-ui) : 64'(ui);
        av = (vi < 0) ? 64'(-vi) : 64'(vi);
        s = au * au + av * av;
        nu = 0;
        nv = 0;
        if (s == 0 || s >= (64'd1 << 62))
            return 1'b0;
        e = 61;
        while (s[e] == 1'b0)
            e--;
        m = s << (63 - e);
        f = 0;
        // Bit-serial log2: square, and take a one whenever the square reaches two.
        for (int i = 0; i < LOG_BITS; i++)
        begin
            prod = 128'(m) * 128'(m);
            f = f << 1;
            if (prod[127])
            begin
                f[0] = 1'b1;
                m = prod[127:64];
            end
            else
                m = prod[126:63];
        end
        t = (64'(62 - e) << LOG_BITS) - f;
        prod = 128'(TWO_LN2) * 128'(t);
        nu = scale_component(ui, prod[127:65], s);
        nv = scale_component(vi, prod[127:65], s);
        return 1'b1;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch: %s got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        logic [31:0]  nu;
        logic [31:0]  nv;
        normal_word_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (predict_normals(u_word, v_word, nu, nv))
                begin
                    normal_q.push_back('{value: nu, last: 1'b0});
                    normal_q.push_back('{value: nv, last: 1'b1});
                end
            end
            if (out_valid && out_ready)
            begin
                if (normal_q.size() == 0)
                    report("unexpected word", normal_value, 32'd0);
                else
                begin
                    want = normal_q.pop_front();
                    if (normal_value !== want.value)
                        report("normal_value", normal_value, want.value);
                    if (last_of_pair !== want.last)
                        report("last_of_pair", 32'(last_of_pair), 32'(want.last));
                end
            end
            pending = normal_q.size();
        end
    end

endmodule

// ===== bench/tb_gaussian_polar_sampler_top.sv =====
// Testbench top for the polar Gaussian sampler: clock, reset, uniform-pair
// stimulus and receiver stalls. Depends on gaussian_polar_sampler_top and gps_checker.
module tb_gaussian_polar_sampler_top;

    localparam int IDLE_LIMIT = 6000;
    localparam int RANDOM_PAIRS = 1200;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [31:0]        u_word;
    logic [31:0]        v_word;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] normal_value;
    logic               last_of_pair;
    int                 errors;
    int                 pending;
    int                 idle_cycles = 0;

    gaussian_polar_sampler_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .u_word       (u_word),
        .v_word       (v_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .normal_value (normal_value),
        .last_of_pair (last_of_pair)
    );

    gps_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .u_word       (u_word),
        .v_word       (v_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .normal_value (normal_value),
        .last_of_pair (last_of_pair),
        .errors       (errors),
        .pending      (pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offers one pair; returns at the edge where it is taken.
    task automatic send_pair(input logic [31:0] uw, input logic [31:0] vw, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        u_word <= uw;
        v_word <= vw;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Random component near the center, to reach very small radii.
    function automatic logic [31:0] near_center();
        return 32'h8000_0000 + 32'($signed($urandom_range(0, 2047)) - 1024);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off that fills the pipeline.
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        repeat (300) @(posedge clk);
        out_ready <= 1'b0;
        repeat (1000) @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            @(posedge clk);
            gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [31:0] uw;
        logic [31:0] vw;
        int          roll;
        in_valid = 1'b0;
        u_word = 32'd0;
        v_word = 32'd0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corners, the center, the circle's edge and zero components.
        send_pair(32'h0000_0000, 32'h0000_0000, 0);
        send_pair(32'h8000_0000, 32'h8000_0000, 0);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_pair(32'h0000_0000, 32'h8000_0000, 1);
        send_pair(32'h8000_0000, 32'h0000_0000, 0);
        send_pair(32'hFFFF_FFFF, 32'h8000_0000, 0);
        send_pair(32'h8000_0000, 32'hFFFF_FFFF, 0);
        send_pair(32'h0000_0001, 32'h8000_0000, 2);
        send_pair(32'h8000_0001, 32'h8000_0000, 0);
        send_pair(32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_pair(32'h8000_0001, 32'h8000_0001, 0);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_pair(32'hC000_0000, 32'h4000_0000, 0);
        send_pair(32'hDA82_799A, 32'hDA82_799A, 0);
        send_pair(32'h25_7D8666, 32'h25_7D8666, 0);
        send_pair(32'h4000_0000, 32'hFFFF_FFFF, 3);
        send_pair(32'h5555_5555, 32'hAAAA_AAAA, 0);
        send_pair(32'hAAAA_AAAA, 32'h5555_5555, 0);

        for (int n = 0; n < RANDOM_PAIRS; n++)
        begin
            roll = $urandom_range(0, 99);
            uw = $urandom();
            vw = $urandom();
            if (roll < 8)
                uw = near_center();
            else if (roll < 16)
                vw = near_center();
            else if (roll < 20)
            begin
                uw = near_center();
                vw = near_center();
            end
            send_pair(uw, vw, pick_gap());
        end
        in_valid <= 1'b0;

        // Let the checker see the last accepted pair before reading its count.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
